FILE: hdl/mts_pkg.sv
// Shared types and constant tables for the melody tone sequencer.
// No dependencies; the core and the testbench take this package in.
package mts_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  localparam int NUM_W   = 19;
  localparam int DIV_W   = 13;
  localparam int PITCHES = 14;

  // 240 times the pitch frequency in hertz, the dividend of the note length.
  localparam logic [NUM_W-1:0] NOTE_SCALE [PITCHES] = '{
    19'(240 * 523),  19'(240 * 587),  19'(240 * 659),  19'(240 * 698),
    19'(240 * 784),  19'(240 * 880),  19'(240 * 988),  19'(240 * 1047),
    19'(240 * 1175), 19'(240 * 1319), 19'(240 * 1397), 19'(240 * 1568),
    19'(240 * 1760), 19'(240 * 1976)
  };

  // Pitch numbers outside one to fourteen are pinned to the nearest end.
  function automatic logic [3:0] pitch_sel(input logic [3:0] pitch);
    logic [3:0] sel;
    if (pitch == 4'd0) begin
      sel = 4'd0;
    end else if (pitch == 4'd15) begin
      sel = 4'd13;
    end else begin
      sel = pitch - 4'd1;
    end
    return sel;
  endfunction

endpackage

FILE: hdl/mts_if.sv
// Valid/ready channel interfaces for the command and result words.
// Stand-alone; used by melody_tone_sequencer_core.
interface mts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] entry_index;
  logic [3:0] entry_note;
  logic [4:0] entry_length;
  logic [7:0] start_speed;

  modport source(output valid, action, entry_index, entry_note, entry_length, start_speed,
                 input ready);
  modport sink(input valid, action, entry_index, entry_note, entry_length, start_speed,
               output ready);
endinterface

interface mts_rsp_if;
  logic        valid;
  logic        ready;
  logic        buzzer_level;
  logic [15:0] reload_value;
  logic        playing;

  modport source(output valid, buzzer_level, reload_value, playing, input ready);
  modport sink(input valid, buzzer_level, reload_value, playing, output ready);
endinterface

FILE: hdl/melody_tone_sequencer_core.sv
// Melody tone sequencer: note memory, tick sequencer and serial note-length divider.
// Depends on mts_pkg and the channel interfaces in mts_if.sv.
//
// Each command word on req gives exactly one result word on rsp. Load words write
// a note entry, start latches the tempo and begins play, stop ends play, and a tick
// toggles the buzzer while the gate is open and steps the sequencer. Loads, starts,
// stops and ordinary ticks go from idle straight to done. A tick that begins a new
// note registers the 5 by 8 bit product of length code and tempo in a multiply state,
// then a restoring divider forms the 19-bit quotient for the note length one quotient
// bit per cycle. A new word is taken only once the previous one has finished; a result
// that waits to be taken does not block the next word until that one finishes.
module melody_tone_sequencer_core #(
  parameter int MELODY_DEPTH = 256,
  parameter int CLOCK_HZ     = 12000000
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [8:0]   cfg_wr_data,
  mts_req_if.sink      req,
  mts_rsp_if.source    rsp
);
  import mts_pkg::*;

  localparam int ADDR_W    = $clog2(MELODY_DEPTH);
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int CLK_DIV12 = CLOCK_HZ / 12;

  localparam logic [15:0] RELOAD_TABLE [PITCHES] = '{
    16'(65536 - CLK_DIV12 / 1046), 16'(65536 - CLK_DIV12 / 1174),
    16'(65536 - CLK_DIV12 / 1318), 16'(65536 - CLK_DIV12 / 1396),
    16'(65536 - CLK_DIV12 / 1568), 16'(65536 - CLK_DIV12 / 1760),
    16'(65536 - CLK_DIV12 / 1976), 16'(65536 - CLK_DIV12 / 2094),
    16'(65536 - CLK_DIV12 / 2350), 16'(65536 - CLK_DIV12 / 2638),
    16'(65536 - CLK_DIV12 / 2794), 16'(65536 - CLK_DIV12 / 3136),
    16'(65536 - CLK_DIV12 / 3520), 16'(65536 - CLK_DIV12 / 3952)
  };

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  // Latched command word.
  action_t    act_r;
  logic [7:0] idx_r;
  logic [3:0] note_r;
  logic [4:0] len_r;
  logic [7:0] speed_r;

  // Sequencer state.
  logic [8:0]  melody_length;
  logic [8:0]  position;
  logic [15:0] tick_count;
  logic [15:0] note_ticks;
  logic [15:0] sound_ticks;
  logic        gate_on;
  logic        play_flag;
  logic [7:0]  tempo;
  logic [15:0] current_reload;
  logic        pin_level;

  // Note memory: pitch in the top four bits, length code below.
  logic [8:0] entry_mem [MELODY_DEPTH];
  logic [8:0] rd_entry;

  // Divider.
  logic [NUM_W-1:0] div_q;
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] div_d;
  logic [CNT_W-1:0] div_cnt;
  logic             div_zero;
  logic [15:0]      new_reload;

  // Result register.
  logic        rsp_valid;
  logic        rsp_buzzer;
  logic [15:0] rsp_reload;
  logic        rsp_playing;

  logic        accept;
  logic        slot_free;
  logic        commit;
  logic        begin_now;
  logic        pos_in_range;
  logic        load_in_range;
  logic [3:0]  sel;
  logic [4:0]  code;
  logic [DIV_W:0] rem_sh;
  logic        rem_ge;
  logic [15:0] nt_final;
  logic [15:0] st_final;
  logic [15:0] tc_inc;
  logic        pin_after;
  logic        play_after;

  assign req.ready        = (state == S_IDLE);
  assign accept           = req.valid && req.ready;
  assign slot_free        = !rsp_valid || rsp.ready;
  assign commit           = (state == S_DONE) && slot_free;
  assign pos_in_range     = 32'(position) < MELODY_DEPTH;
  assign load_in_range    = 32'(idx_r) < MELODY_DEPTH;

  // A tick begins a note only while playing, within the melody, between notes.
  assign begin_now = (action_t'(req.action) == ACT_TICK) && play_flag &&
                     (position < melody_length) && (tick_count == 16'd0);

  assign sel  = pitch_sel(pos_in_range ? rd_entry[8:5] : 4'd0);
  assign code = pos_in_range ? rd_entry[4:0] : 5'd0;

  assign rem_sh = {div_rem, div_q[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_d};

  assign nt_final = div_zero ? 16'hFFFF : div_q[15:0];
  assign st_final = nt_final - {2'b00, nt_final[15:2]};
  assign tc_inc   = tick_count + 16'd1;

  always_comb begin
    pin_after  = pin_level;
    play_after = play_flag;
    case (act_r)
      ACT_TICK: begin
        pin_after = gate_on ? ~pin_level : 1'b1;
        if (play_flag && !(position < melody_length)) begin
          play_after = 1'b0;
        end
      end
      ACT_START: play_after = 1'b1;
      ACT_STOP:  play_after = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (commit && (act_r == ACT_LOAD) && load_in_range) begin
      entry_mem[ADDR_W'(idx_r)] <= {note_r, len_r};
    end
    rd_entry <= entry_mem[ADDR_W'(position)];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= action_t'(req.action);
      idx_r   <= req.entry_index;
      note_r  <= req.entry_note;
      len_r   <= req.entry_length;
      speed_r <= req.start_speed;
    end
    if (state == S_MUL) begin
      div_d      <= {8'd0, code} * {5'd0, tempo};
      div_zero   <= (code == 5'd0) || (tempo == 8'd0);
      div_q      <= NOTE_SCALE[sel];
      div_rem    <= '0;
      div_cnt    <= '0;
      new_reload <= RELOAD_TABLE[sel];
    end else if (state == S_DIV) begin
      div_q   <= {div_q[NUM_W-2:0], rem_ge};
      div_rem <= rem_ge ? DIV_W'(rem_sh - {1'b0, div_d}) : rem_sh[DIV_W-1:0];
      div_cnt <= div_cnt + 1'b1;
    end
    if (commit) begin
      rsp_buzzer  <= pin_after;
      rsp_reload  <= current_reload;
      rsp_playing <= play_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      melody_length  <= 9'd240;
      position       <= '0;
      tick_count     <= '0;
      note_ticks     <= '0;
      sound_ticks    <= '0;
      gate_on        <= 1'b1;
      play_flag      <= 1'b0;
      tempo          <= 8'd48;
      current_reload <= 16'hFF00;
      pin_level      <= 1'b1;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        melody_length <= cfg_wr_data;
      end
      if (rsp.ready && !commit) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= begin_now ? S_MUL : S_DONE;
          end
        end
        S_MUL: state <= S_DIV;
        S_DIV: begin
          if (div_cnt == CNT_W'(NUM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b1;
            case (act_r)
              ACT_TICK: begin
                pin_level <= pin_after;
                if (!play_flag) begin
                  position    <= '0;
                  tick_count  <= '0;
                  note_ticks  <= '0;
                  sound_ticks <= '0;
                  gate_on     <= 1'b0;
                end else if (!(position < melody_length)) begin
                  play_flag <= 1'b0;
                end else if (tick_count == 16'd0) begin
                  current_reload <= new_reload;
                  note_ticks     <= nt_final;
                  sound_ticks    <= st_final;
                  gate_on        <= 1'b1;
                  tick_count     <= 16'd1;
                end else if (tick_count == note_ticks) begin
                  tick_count <= '0;
                  position   <= position + 9'd1;
                end else begin
                  tick_count <= tc_inc;
                  if (tc_inc == sound_ticks) begin
                    gate_on <= 1'b0;
                  end
                end
              end
              ACT_START: begin
                tempo     <= speed_r;
                play_flag <= 1'b1;
              end
              ACT_STOP: begin
                gate_on   <= 1'b0;
                play_flag <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.buzzer_level = rsp_buzzer;
  assign rsp.reload_value = rsp_reload;
  assign rsp.playing      = rsp_playing;

endmodule

FILE: test/melody_tone_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the melody tone sequencer: watches the command, result and register ports.
// Holds its own copy of the sequencer state. Needs mts_pkg and the channel interfaces.
module melody_tone_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  mts_req_if         req,
  mts_rsp_if         rsp,
  output int         failures,
  output int         results_seen,
  output int         pending,
  output int         notes_begun,
  output int         melodies_ended
);
  import mts_pkg::*;

  localparam int CLOCK_HZ = 12000000;

  typedef struct packed {
    logic        level;
    logic [15:0] reload;
    logic        playing;
  } tone_word_t;

  tone_word_t  expected_tones[$];

  logic [3:0]  pitch_mem [256];
  logic [4:0]  code_mem  [256];
  logic [8:0]  melody_len;
  logic [8:0]  note_pos;
  logic [15:0] tick_cnt;
  logic [15:0] note_len;
  logic [15:0] gate_len;
  logic        gate_open;
  logic        play_on;
  logic [7:0]  tempo;
  logic [15:0] reload;
  logic        pin;

  int fail_total;
  int seen_total;
  int begun_total;
  int ended_total;

  function automatic int tone_hz(input int sel);
    case (sel)
      0:       return 523;
      1:       return 587;
      2:       return 659;
      3:       return 698;
      4:       return 784;
      5:       return 880;
      6:       return 988;
      7:       return 1047;
      8:       return 1175;
      9:       return 1319;
      10:      return 1397;
      11:      return 1568;
      12:      return 1760;
      default: return 1976;
    endcase
  endfunction

  task automatic log_failure(input string what);
    fail_total++;
    if (fail_total <= 10) begin
      $display("[%0t] tone check: %s", $time, what);
    end
  endtask

  task automatic begin_note();
    int pitch;
    int code;
    int hz;
    int divisor;
    pitch = 0;
    code  = 0;
    if (!note_pos[8]) begin
      pitch = int'(pitch_mem[note_pos[7:0]]);
      code  = int'(code_mem[note_pos[7:0]]);
    end
    // Pitch numbers outside the table play as the nearest end of it.
    if (pitch < 1) pitch = 1;
    if (pitch > 14) pitch = 14;
    hz      = tone_hz(pitch - 1);
    reload  = 16'(65536 - (CLOCK_HZ / 12) / (hz * 2));
    divisor = code * int'(tempo);
    note_len  = (divisor == 0) ? 16'hFFFF : 16'((240 * hz) / divisor);
    gate_len  = note_len - (note_len >> 2);
    gate_open = 1'b1;
    tick_cnt  = 16'd1;
    begun_total++;
  endtask

  task automatic advance_sequencer();
    if (!play_on) begin
      note_pos  = '0;
      tick_cnt  = '0;
      note_len  = '0;
      gate_len  = '0;
      gate_open = 1'b0;
    end else if (note_pos >= melody_len) begin
      play_on = 1'b0;
      ended_total++;
    end else if (tick_cnt == 16'd0) begin
      begin_note();
    end else if (tick_cnt == note_len) begin
      tick_cnt = '0;
      note_pos = note_pos + 9'd1;
    end else begin
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt == gate_len) gate_open = 1'b0;
    end
  endtask

  task automatic predict_tone_word(input action_t act, input logic [7:0] idx,
                                   input logic [3:0] note, input logic [4:0] code,
                                   input logic [7:0] speed, output tone_word_t word);
    logic [15:0] reload_before;
    reload_before = reload;
    case (act)
      ACT_TICK: begin
        pin = gate_open ? ~pin : 1'b1;
        advance_sequencer();
      end
      ACT_LOAD: begin
        pitch_mem[idx] = note;
        code_mem[idx]  = code;
      end
      ACT_START: begin
        tempo   = speed;
        play_on = 1'b1;
      end
      ACT_STOP: begin
        gate_open = 1'b0;
        play_on   = 1'b0;
      end
      default: ;
    endcase
    word.level   = pin;
    word.reload  = reload_before;
    word.playing = play_on;
  endtask

  always @(posedge clk) begin : watch
    tone_word_t want;
    if (rst) begin
      expected_tones.delete();
      melody_len = 9'd240;
      note_pos   = '0;
      tick_cnt   = '0;
      note_len   = '0;
      gate_len   = '0;
      gate_open  = 1'b1;
      play_on    = 1'b0;
      tempo      = 8'd48;
      reload     = 16'hFF00;
      pin        = 1'b1;
    end else begin
      if (cfg_wr_en) melody_len = cfg_wr_data;
      if (req.valid && req.ready) begin
        predict_tone_word(action_t'(req.action), req.entry_index, req.entry_note,
                          req.entry_length, req.start_speed, want);
        expected_tones.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        seen_total++;
        if (expected_tones.size() == 0) begin
          log_failure("result word arrived with nothing expected");
        end else begin
          want = expected_tones.pop_front();
          if (rsp.buzzer_level !== want.level || rsp.reload_value !== want.reload ||
              rsp.playing !== want.playing) begin
            log_failure($sformatf({"word %0d: level %0b/%0b reload %h/%h playing %0b/%0b",
                                   " (expected/actual)"}, seen_total,
                                  want.level, rsp.buzzer_level, want.reload,
                                  rsp.reload_value, want.playing, rsp.playing));
          end
        end
      end
    end
    // Counts are registered on the clock so that the stimulus never races the update.
    failures       <= fail_total;
    results_seen   <= seen_total;
    pending        <= expected_tones.size();
    notes_begun    <= begun_total;
    melodies_ended <= ended_total;
  end

endmodule

FILE: test/melody_tone_sequencer_core_tb.sv
`timescale 1ns / 100ps
// Top of the melody tone sequencer testbench: clock, reset, command stimulus and verdict.
// Needs mts_pkg, the channel interfaces, the core and melody_tone_checker.
module melody_tone_sequencer_core_tb;
  import mts_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int SETTLE    = 40;
  localparam int PHASE_WORDS = 20;

  logic clk;
  logic rst;
  logic       cfg_wr_en;
  logic [8:0] cfg_wr_data;

  int send_idle_pct;
  int recv_idle_pct;
  int words_sent;
  int cycle_count;

  int failures;
  int results_seen;
  int pending;
  int notes_begun;
  int melodies_ended;

  mts_req_if req_ch ();
  mts_rsp_if rsp_ch ();

  melody_tone_sequencer_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  melody_tone_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .failures       (failures),
    .results_seen   (results_seen),
    .pending        (pending),
    .notes_begun    (notes_begun),
    .melodies_ended (melodies_ended)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(input action_t act, input logic [7:0] idx, input logic [3:0] note,
                           input logic [4:0] code, input logic [7:0] speed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.entry_index  <= idx;
    req_ch.entry_note   <= note;
    req_ch.entry_length <= code;
    req_ch.start_speed  <= speed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(ACT_TICK, 8'($urandom), 4'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [3:0] note, input logic [4:0] code);
    send_word(ACT_LOAD, idx, note, code, 8'($urandom));
  endtask

  task automatic send_start(input logic [7:0] speed);
    send_word(ACT_START, 8'($urandom), 4'($urandom), 5'($urandom), speed);
  endtask

  task automatic send_stop();
    send_word(ACT_STOP, 8'($urandom), 4'($urandom), 5'($urandom), 8'($urandom));
  endtask

  // The sender holds off until every result word is back, then the register is written.
  task automatic set_melody_length(input logic [8:0] len);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen < words_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One stretch of play: at times one to three entry rewrites, a start, a run of ticks, then usually a stop.
  task automatic play_phrase();
    int n_loads;
    int n_ticks;
    logic [7:0] idx;
    logic [4:0] code;
    n_loads = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n_loads) begin
      idx  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      code = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 15)) : 5'($urandom_range(20, 31));
      send_load(idx, 4'($urandom), code);
    end
    if ($urandom_range(0, 9) == 0) begin
      send_word(action_t'($urandom_range(0, 3)), 8'($urandom), 4'($urandom), 5'($urandom),
                8'($urandom));
    end
    send_start(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(200, 255)));
    n_ticks = $urandom_range(10, 40);
    repeat (n_ticks) begin
      if ($urandom_range(0, 59) == 0) begin
        send_start(8'($urandom_range(200, 255)));
      end else begin
        send_tick();
      end
    end
    if ($urandom_range(0, 2) != 0) send_stop();
    repeat ($urandom_range(1, 3)) send_tick();
  endtask

  task automatic run_phase(input logic [8:0] len, input int send_pct, input int recv_pct);
    int first_word;
    send_stop();
    set_melody_length(len);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_word = words_sent;
    while (words_sent - first_word < PHASE_WORDS) play_phrase();
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    req_ch.valid        = 1'b0;
    req_ch.action       = ACT_TICK;
    req_ch.entry_index  = '0;
    req_ch.entry_note   = '0;
    req_ch.entry_length = '0;
    req_ch.start_speed  = '0;
    send_idle_pct       = 36;
    recv_idle_pct       = 60;
    words_sent          = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every entry is written before any play, so no note ever reads an empty slot.
    for (int i = 0; i < 256; i++) begin
      send_load(8'(i), 4'($urandom), 5'($urandom_range(24, 31)));
    end

    // Directed words, still on the reset melody length.
    send_tick();                  // the gate is open out of reset, so the pin toggles
    send_tick();                  // idle tick with the gate closed sets the pin high
    send_load(8'd0, 4'd0, 5'd0);  // lowest pitch number and a zero length code
    send_load(8'd255, 4'd14, 5'd31);
    send_start(8'd255);
    send_tick();                  // note with a zero divisor saturates its length
    send_tick();
    send_tick();
    send_start(8'd0);             // a start while playing only latches the tempo
    send_stop();
    send_tick();
    send_load(8'd0, 4'd14, 5'd1);
    send_start(8'd1);             // note length overflows sixteen bits and is truncated
    send_tick();
    send_tick();
    send_stop();
    send_start(8'd0);             // zero tempo is a zero divisor as well
    send_tick();
    send_tick();
    send_stop();
    send_load(8'd0, 4'd15, 5'd31);
    send_start(8'd255);
    send_tick();                  // highest pitch number plays as the top of the table
    send_tick();
    send_stop();

    run_phase(9'd0, 36, 60);
    run_phase(9'd256, 36, 60);
    run_phase(9'd1, 60, 36);
    run_phase(9'd3, 60, 36);
    run_phase(9'd2, 0, 0);
    run_phase(9'($urandom_range(1, 6)), 0, 0);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen < words_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Summary: %0d command words, %0d result words checked,",
             words_sent, results_seen);
    $display("         %0d notes begun, %0d melodies played out",
             notes_begun, melodies_ended);
    if (failures == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mts_pkg.sv
hdl/mts_if.sv
hdl/melody_tone_sequencer_core.sv
test/melody_tone_checker.sv
test/melody_tone_sequencer_core_tb.sv
